>>> hdl/ser_pkg.sv
// Package: shared types, register codes and defaults for the sonar echo ranger.
`default_nettype none

package ser_pkg;

  // Default build constants
  localparam int TIME_WIDTH_DEF       = 32;
  localparam int PULSE_HIGH_TICKS_DEF = 10;
  localparam int PULSE_LEAD_TICKS_DEF = 2;

  // Configuration register widths and reset values
  localparam int MAX_ECHO_W  = 20;
  localparam int MARGIN_W    = 16;
  localparam int SCALE_W     = 16;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int LIMIT_W     = MAX_ECHO_W + 1;

  localparam logic [MAX_ECHO_W-1:0] MAX_ECHO_RST = MAX_ECHO_W'(25000);
  localparam logic [MARGIN_W-1:0]   MARGIN_RST   = MARGIN_W'(1000);
  localparam logic [SCALE_W-1:0]    SCALE_RST    = SCALE_W'(11239);

  // Result field widths
  localparam int RANGE_W = 18;
  localparam int STAMP_W = 32;
  localparam int Q_SHIFT = 16;
  localparam logic [RANGE_W-1:0] RANGE_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ECHO       = 2'd0,
    CFG_TIMEOUT_MARGIN = 2'd1,
    CFG_SCALE          = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_WAIT_RISE = 2'd1,
    PH_WAIT_FALL = 2'd2
  } phase_t;

  typedef struct packed {
    logic start_request;
    logic echo_level;
  } in_beat_t;

  typedef struct packed {
    logic               trigger_out;
    logic               start_accepted;
    logic               busy_res;
    logic               reading_new;
    logic               reading_valid;
    logic               range_infinite;
    logic [RANGE_W-1:0] range_mm;
    logic [STAMP_W-1:0] reading_stamp_us;
  } out_beat_t;

endpackage

`default_nettype wire

>>> hdl/ser_stream_if.sv
// Interface: valid/ready stream channel with a typed payload.
`default_nettype none

interface ser_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/sonar_echo_ranger.sv
// Top level: ultrasonic time-of-flight ranging controller, one beat per microsecond tick.
// An accepted input beat's result is registered and appears in the output register in the next cycle.
// Throughput: one beat per cycle; a new beat is taken whenever the output register is
//   empty or is being drained in the same cycle, so the rate is set by out_beat.ready alone.
// The per-tick path is one subtract, a 20x16 multiply and a saturate, then the result register.
// Reset (rst_n low, synchronous) sets the registers to their defaults, the phase to idle,
//   the tick counter and timestamps to zero, and the held reading to invalid; no clearing pass.
`default_nettype none

module sonar_echo_ranger #(
  parameter int TIME_WIDTH       = ser_pkg::TIME_WIDTH_DEF,
  parameter int PULSE_HIGH_TICKS = ser_pkg::PULSE_HIGH_TICKS_DEF,
  parameter int PULSE_LEAD_TICKS = ser_pkg::PULSE_LEAD_TICKS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ser_stream_if.sink                         in_beat,
  ser_stream_if.source                       out_beat,
  input  wire logic                          cfg_we,
  input  wire logic [ser_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ser_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ser_pkg::*;

  // Pulse sequencer counts 1 .. LEAD+HIGH, zero means no pulse running.
  localparam int PULSE_LAST = PULSE_LEAD_TICKS + PULSE_HIGH_TICKS;
  localparam int PSW        = $clog2(PULSE_LAST + 1);
  // Width wide enough to compare elapsed time against limit = max + margin.
  localparam int DW         = (TIME_WIDTH > LIMIT_W) ? TIME_WIDTH : LIMIT_W;
  localparam int PROD_W     = MAX_ECHO_W + SCALE_W;
  localparam int MM_W       = PROD_W - Q_SHIFT;

  // Configuration registers
  logic [MAX_ECHO_W-1:0] max_echo_r;
  logic [MARGIN_W-1:0]   margin_r;
  logic [SCALE_W-1:0]    scale_r;

  // Tick state
  phase_t                phase_r, phase_nxt;
  logic [TIME_WIDTH-1:0] tick_r;
  logic [TIME_WIDTH-1:0] trig_time_r, trig_time_nxt;
  logic [TIME_WIDTH-1:0] rise_time_r, rise_time_nxt;
  logic                  echo_prev_r;
  logic [PSW-1:0]        pulse_r, pulse_nxt;
  logic [RANGE_W-1:0]    held_range_r, held_range_nxt;
  logic                  held_valid_r, held_valid_nxt;
  logic                  held_inf_r, held_inf_nxt;
  logic [STAMP_W-1:0]    held_stamp_r, held_stamp_nxt;

  // Output register
  logic                  out_valid_r;
  out_beat_t             out_data_r, out_data_nxt;

  logic                  accept;
  logic                  start, echo, rising, falling;
  logic                  rise_evt, fall_evt, start_ok, timeout;
  phase_t                phase_mid, phase_post;
  logic [TIME_WIDTH-1:0] dur, since;
  logic [DW-1:0]         dur_ext, since_ext, limit_ext, max_ext;
  logic [LIMIT_W-1:0]    limit;
  logic [PROD_W-1:0]     prod;
  logic [MM_W-1:0]       mm;
  logic [RANGE_W-1:0]    mm_sat;
  logic [PSW-1:0]        pulse_mid;
  logic                  trig;
  logic                  is_new;

  // Take a beat whenever the result register is free or draining this cycle.
  assign in_beat.ready  = !out_valid_r || out_beat.ready;
  assign accept         = in_beat.valid && in_beat.ready;
  assign out_beat.valid = out_valid_r;
  assign out_beat.data  = out_data_r;

  assign start   = in_beat.data.start_request;
  assign echo    = in_beat.data.echo_level;
  assign rising  = echo && !echo_prev_r;
  assign falling = !echo && echo_prev_r;

  // Edges are handled first, then the start request, then the timeout check.
  assign rise_evt = (phase_r == PH_WAIT_RISE) && rising;
  assign fall_evt = (phase_r == PH_WAIT_FALL) && falling;
  assign start_ok = start && (phase_mid == PH_IDLE);

  assign trig_time_nxt = start_ok ? tick_r : trig_time_r;
  assign rise_time_nxt = rise_evt ? tick_r : rise_time_r;

  // Elapsed time since trigger; zero on the tick a start is taken.
  assign since     = tick_r - trig_time_nxt;
  assign since_ext = DW'(since);
  assign limit     = LIMIT_W'(max_echo_r) + LIMIT_W'(margin_r);
  assign limit_ext = DW'(limit);
  assign timeout   = (phase_post != PH_IDLE) && (since_ext > limit_ext);

  // Echo duration to millimetres; the product only matters when dur fits max_echo.
  assign dur     = tick_r - rise_time_r;
  assign dur_ext = DW'(dur);
  assign max_ext = DW'(max_echo_r);
  assign prod    = PROD_W'(dur_ext[MAX_ECHO_W-1:0]) * PROD_W'(scale_r);
  assign mm      = prod[PROD_W-1:Q_SHIFT];
  assign mm_sat  = (mm > MM_W'(RANGE_MAX)) ? RANGE_MAX : mm[RANGE_W-1:0];

  // Next phase: edges, then start, then timeout.
  always_comb begin
    unique case (phase_r)
      PH_WAIT_RISE: phase_mid = rise_evt ? PH_WAIT_FALL : PH_WAIT_RISE;
      PH_WAIT_FALL: phase_mid = fall_evt ? PH_IDLE : PH_WAIT_FALL;
      default:      phase_mid = phase_r;
    endcase
    phase_post = start_ok ? PH_WAIT_RISE : phase_mid;
    phase_nxt  = timeout ? PH_IDLE : phase_post;
  end

  // Trigger pulse: low for the lead ticks, then high, then stop.
  always_comb begin
    pulse_mid = start_ok ? PSW'(1) : pulse_r;
    trig      = 1'b0;
    pulse_nxt = pulse_mid;
    if (pulse_mid != '0) begin
      trig      = (pulse_mid > PSW'(PULSE_LEAD_TICKS));
      pulse_nxt = (pulse_mid >= PSW'(PULSE_LAST)) ? '0 : pulse_mid + PSW'(1);
    end
  end

  // Held reading: a fall closes the measurement, a timeout overrides.
  always_comb begin
    held_valid_nxt = held_valid_r;
    held_inf_nxt   = held_inf_r;
    held_range_nxt = held_range_r;
    held_stamp_nxt = held_stamp_r;
    is_new         = 1'b0;
    if (fall_evt) begin
      is_new         = 1'b1;
      held_stamp_nxt = STAMP_W'(rise_time_r);
      if (dur == '0) begin
        held_valid_nxt = 1'b0;
        held_inf_nxt   = 1'b0;
        held_range_nxt = '0;
      end else if (dur_ext > max_ext) begin
        held_valid_nxt = 1'b1;
        held_inf_nxt   = 1'b1;
        held_range_nxt = '0;
      end else begin
        held_valid_nxt = 1'b1;
        held_inf_nxt   = 1'b0;
        held_range_nxt = mm_sat;
      end
    end
    if (timeout) begin
      is_new         = 1'b1;
      held_valid_nxt = 1'b1;
      held_inf_nxt   = 1'b1;
      held_range_nxt = '0;
      held_stamp_nxt = STAMP_W'(tick_r);
    end
  end

  always_comb begin
    out_data_nxt.trigger_out      = trig;
    out_data_nxt.start_accepted   = start_ok;
    out_data_nxt.busy_res         = (phase_nxt != PH_IDLE);
    out_data_nxt.reading_new      = is_new;
    out_data_nxt.reading_valid    = held_valid_nxt;
    out_data_nxt.range_infinite   = held_inf_nxt;
    out_data_nxt.range_mm         = held_range_nxt;
    out_data_nxt.reading_stamp_us = held_stamp_nxt;
  end

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_echo_r <= MAX_ECHO_RST;
      margin_r   <= MARGIN_RST;
      scale_r    <= SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_ECHO:       max_echo_r <= cfg_wdata[MAX_ECHO_W-1:0];
        CFG_TIMEOUT_MARGIN: margin_r   <= cfg_wdata[MARGIN_W-1:0];
        CFG_SCALE:          scale_r    <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Tick state advances only on an accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      tick_r       <= '0;
      trig_time_r  <= '0;
      rise_time_r  <= '0;
      echo_prev_r  <= 1'b0;
      pulse_r      <= '0;
      held_range_r <= '0;
      held_valid_r <= 1'b0;
      held_inf_r   <= 1'b0;
      held_stamp_r <= '0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      tick_r       <= tick_r + TIME_WIDTH'(1);
      trig_time_r  <= trig_time_nxt;
      rise_time_r  <= rise_time_nxt;
      echo_prev_r  <= echo;
      pulse_r      <= pulse_nxt;
      held_range_r <= held_range_nxt;
      held_valid_r <= held_valid_nxt;
      held_inf_r   <= held_inf_nxt;
      held_stamp_r <= held_stamp_nxt;
    end
  end

  // Result register: load on accept, clear valid when drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_beat.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

>>> verif/tb_sonar_echo_ranger.sv
// Self-checking testbench for the sonar echo ranger: tick-level prediction of every result beat.
module tb_sonar_echo_ranger;
  timeunit 1ns;
  timeprecision 1ps;

  import ser_pkg::*;

  localparam int LEAD_TICKS  = PULSE_LEAD_TICKS_DEF;
  localparam int HIGH_TICKS  = PULSE_HIGH_TICKS_DEF;
  localparam int QUIET_LIMIT = 5000;   // cycles with no beat moving on either channel
  localparam int RANDOM_TICKS = 1200;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_reg_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ser_stream_if #(.payload_t(in_beat_t))  in_ch ();
  ser_stream_if #(.payload_t(out_beat_t)) out_ch ();

  sonar_echo_ranger dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_ch),
    .out_beat (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Ranger prediction state: a private copy of the block's registers and timers.
  // ---------------------------------------------------------------------------
  logic [MAX_ECHO_W-1:0] cfg_max_echo;
  logic [MARGIN_W-1:0]   cfg_margin;
  logic [SCALE_W-1:0]    cfg_scale;

  phase_t             rg_phase;
  logic [31:0]        rg_clock;
  logic [31:0]        rg_trigger_at;
  logic [31:0]        rg_rise_at;
  logic               rg_echo_last;
  logic [3:0]         rg_pulse_step;
  logic [RANGE_W-1:0] held_mm;
  logic               held_valid;
  logic               held_inf;
  logic [STAMP_W-1:0] held_stamp;

  // Expected result beats, oldest first, and run statistics.
  out_beat_t pending_readings[$];
  int bad_beats = 0;
  int beats_seen = 0;
  int ticks_sent = 0;
  int n_finite = 0;
  int n_saturated = 0;
  int n_beyond = 0;
  int n_timeout = 0;
  int n_ignored_start = 0;

  // Sender burst shaping and receiver hold-off request.
  bit gaps_on = 1'b1;
  int burst_left = 0;
  int holdoff_req = 0;

  // Advance the predicted ranger by one microsecond tick and return that tick's result.
  // Echo edges come first, then the start request, then the timeout check.
  function automatic out_beat_t ranger_tick(bit start, bit echo);
    out_beat_t   r;
    logic [31:0] now;
    logic [31:0] dur;
    logic [31:0] since;
    logic [32:0] give_up;
    logic [47:0] prod;
    logic [31:0] mm;
    bit          rising;
    bit          falling;
    bit          fresh;
    bit          took;
    bit          trig;

    now     = rg_clock;
    rising  = echo && !rg_echo_last;
    falling = !echo && rg_echo_last;
    fresh   = 1'b0;
    took    = 1'b0;
    trig    = 1'b0;
    rg_echo_last = echo;

    if (rg_phase == PH_WAIT_RISE && rising) begin
      rg_rise_at = now;
      rg_phase   = PH_WAIT_FALL;
    end else if (rg_phase == PH_WAIT_FALL && falling) begin
      dur        = now - rg_rise_at;
      held_stamp = rg_rise_at;
      held_mm    = '0;
      if (dur == 0) begin
        held_valid = 1'b0;
        held_inf   = 1'b0;
      end else if (dur > 32'(cfg_max_echo)) begin
        held_valid = 1'b1;
        held_inf   = 1'b1;
        n_beyond++;
      end else begin
        // Q16 scale: take the integer part of duration times millimetres per tick.
        prod = 48'(dur) * 48'(cfg_scale);
        mm   = 32'(prod >> Q_SHIFT);
        if (mm > 32'(RANGE_MAX)) begin
          mm = 32'(RANGE_MAX);
          n_saturated++;
        end
        held_valid = 1'b1;
        held_inf   = 1'b0;
        held_mm    = mm[RANGE_W-1:0];
        n_finite++;
      end
      rg_phase = PH_IDLE;
      fresh    = 1'b1;
    end

    if (start && rg_phase == PH_IDLE) begin
      rg_phase      = PH_WAIT_RISE;
      rg_trigger_at = now;
      rg_pulse_step = 4'd1;
      took          = 1'b1;
    end else if (start) begin
      n_ignored_start++;
    end

    // Trigger pulse: low for the lead ticks, then high, then done.
    if (rg_pulse_step != 0) begin
      trig = (rg_pulse_step > LEAD_TICKS);
      rg_pulse_step++;
      if (rg_pulse_step > LEAD_TICKS + HIGH_TICKS) rg_pulse_step = '0;
    end

    if (rg_phase != PH_IDLE) begin
      since   = now - rg_trigger_at;
      give_up = 33'(cfg_max_echo) + 33'(cfg_margin);
      if ({1'b0, since} > give_up) begin
        rg_phase   = PH_IDLE;
        held_valid = 1'b1;
        held_inf   = 1'b1;
        held_mm    = '0;
        held_stamp = now;
        fresh      = 1'b1;
        n_timeout++;
      end
    end

    rg_clock = now + 1;

    r.trigger_out      = trig;
    r.start_accepted   = took;
    r.busy_res         = (rg_phase != PH_IDLE);
    r.reading_new      = fresh;
    r.reading_valid    = held_valid;
    r.range_infinite   = held_inf;
    r.range_mm         = held_mm;
    r.reading_stamp_us = held_stamp;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offer one tick beat, predict it when it is taken, then maybe idle.
  // Called at a falling edge; returns at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_tick(bit start, bit echo);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data  <= in_beat_t'{start, echo};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_readings.push_back(ranger_tick(start, echo));
    ticks_sent++;
    @(negedge clk);
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        // Pick the next burst: mostly short ones, sometimes a long unbroken run.
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 20);
        gap = $urandom_range(1, 6);
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Hold the echo line at one level for n ticks, with occasional start requests.
  task automatic hold_echo(int n, bit lvl, int start_pct);
    repeat (n) send_tick($urandom_range(0, 99) < start_pct, lvl);
  endtask

  // Stop offering beats and wait until every predicted reading has come out.
  task automatic drain_readings();
    in_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    // Let the output register settle before touching registers.
    repeat (2) @(negedge clk);
  endtask

  // Write all three registers while the ranger is quiet, and mirror them.
  task automatic set_config(int max_echo, int margin, int scale);
    drain_readings();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_ECHO;
    cfg_wdata <= CFG_DATA_W'(max_echo);
    @(negedge clk);
    cfg_index <= CFG_TIMEOUT_MARGIN;
    cfg_wdata <= CFG_DATA_W'(margin);
    @(negedge clk);
    cfg_index <= CFG_SCALE;
    cfg_wdata <= CFG_DATA_W'(scale);
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_max_echo = MAX_ECHO_W'(max_echo);
    cfg_margin   = MARGIN_W'(margin);
    cfg_scale    = SCALE_W'(scale);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Power-on defaults: edges while idle are ignored, then one short echo.
  task automatic test_defaults_and_idle_edges();
    hold_echo(2, 1'b0, 0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    hold_echo(3, 1'b0, 0);
    hold_echo(5, 1'b1, 0);
    send_tick(1'b0, 1'b0);
  endtask

  // A start while busy is dropped; a start during a running pulse restarts it.
  task automatic test_pulse_restart_and_busy_start();
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    hold_echo(14, 1'b0, 0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
  endtask

  // Echo already high at trigger: only a fresh rising edge may start the timing.
  task automatic test_echo_high_at_trigger();
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    hold_echo(2, 1'b1, 0);
    hold_echo(2, 1'b0, 0);
    hold_echo(3, 1'b1, 0);
    send_tick(1'b0, 1'b0);
  endtask

  // Smallest limits: finite reading at zero scale, timeout, long echo, and a
  // fall landing on the timeout tick where the fall must win.
  task automatic test_limits_and_timeouts();
    set_config(1, 0, 0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    hold_echo(3, 1'b0, 0);
    send_tick(1'b1, 1'b0);
    hold_echo(2, 1'b1, 0);
    send_tick(1'b0, 1'b0);
    set_config(5, 0, 65535);
    send_tick(1'b1, 1'b0);
    hold_echo(5, 1'b1, 0);
    send_tick(1'b0, 1'b0);
  endtask

  // Largest registers and a long unbroken echo: widest scale operand for the multiply.
  task automatic test_full_scale_registers();
    set_config(1048575, 65535, 65535);
    gaps_on = 1'b0;
    send_tick(1'b1, 1'b0);
    hold_echo(300, 1'b1, 0);
    send_tick(1'b0, 1'b0);
    gaps_on = 1'b1;
  endtask

  // Receiver holds off for a long stretch while ticks keep coming, so the
  // output register fills and the input stalls; then pause for a full drain.
  task automatic test_backpressure();
    set_config(30, 10, 40000);
    gaps_on = 1'b0;
    holdoff_req = 400;
    send_tick(1'b1, 1'b0);
    hold_echo(5, 1'b0, 0);
    hold_echo(8, 1'b1, 0);
    hold_echo(60, 1'b0, 10);
    gaps_on = 1'b1;
    drain_readings();
  endtask

  // Random measurements over several register settings: mostly well-formed
  // trigger/rise/fall sequences with random timing, plus line noise.
  task automatic test_random_measurements(int target);
    int phase_end;
    int give_up;
    int pre;
    int hi;
    int mx;
    int mg;
    int sc;
    bit lvl;
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        case ($urandom_range(0, 9))
          0, 1:    mx = $urandom_range(1, 1048575);
          2:       mx = 1;
          default: mx = $urandom_range(2, 48);
        endcase
        mg = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
        case ($urandom_range(0, 3))
          0:       sc = 0;
          1:       sc = 65535;
          default: sc = $urandom_range(0, 65535);
        endcase
        set_config(mx, mg, sc);
      end
      phase_end = ticks_sent + target / 6;
      while (ticks_sent < phase_end) begin
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(1, 12))
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          lvl = ($urandom_range(0, 4) == 0);
          send_tick(1'b1, lvl);
          if (lvl) hold_echo($urandom_range(1, 6), 1'b1, 20);
          give_up = int'(cfg_max_echo) + int'(cfg_margin);
          // Near the give-up point often enough to hit timeouts where that is short.
          pre = (give_up <= 60) ? $urandom_range(0, give_up + 3) : $urandom_range(0, 15);
          hi  = (cfg_max_echo <= 40) ? $urandom_range(1, int'(cfg_max_echo) + 3)
                                     : $urandom_range(1, 40);
          hold_echo(pre, 1'b0, 20);
          hold_echo(hi, 1'b1, 20);
          hold_echo($urandom_range(1, 5), 1'b0, 30);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall on a repeating random pattern, or hold off when asked.
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    int pos;
    logic [15:0] pat;
    out_ch.ready = 1'b0;
    stall_left = 0;
    pos = 0;
    pat = '1;
    forever begin
      @(negedge clk);
      if (holdoff_req > 0) begin
        stall_left = holdoff_req;
        holdoff_req = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        // New pattern each time pos wraps to zero; all-ones gives stretches with no stalls.
        if (pos == 0) begin
          case ($urandom_range(0, 3))
            0:       pat = '1;
            1:       pat = 16'($urandom);
            default: pat = 16'($urandom) | 16'($urandom);
          endcase
        end
        out_ch.ready <= pat[pos % 16];
        pos = (pos + 1) % 64;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each result beat with the oldest predicted reading.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_seen++;
      if (pending_readings.size() == 0) begin
        bad_beats++;
        if (bad_beats <= 10) $display("result beat %0d arrived with no tick pending", beats_seen);
      end else begin
        want = pending_readings.pop_front();
        if (out_ch.data !== want) begin
          bad_beats++;
          if (bad_beats <= 10) begin
            $display("beat %0d exp: trig=%b acc=%b busy=%b new=%b valid=%b inf=%b mm=%0d stamp=%0d",
                     beats_seen, want.trigger_out, want.start_accepted, want.busy_res,
                     want.reading_new, want.reading_valid, want.range_infinite,
                     want.range_mm, want.reading_stamp_us);
            $display("beat %0d got: trig=%b acc=%b busy=%b new=%b valid=%b inf=%b mm=%0d stamp=%0d",
                     beats_seen, out_ch.data.trigger_out, out_ch.data.start_accepted,
                     out_ch.data.busy_res, out_ch.data.reading_new, out_ch.data.reading_valid,
                     out_ch.data.range_infinite, out_ch.data.range_mm,
                     out_ch.data.reading_stamp_us);
          end
        end
      end
    end
  end

  // Watchdog: give up when no beat moves on either channel for too long.
  always @(posedge clk) begin
    int quiet;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles, %0d readings pending",
               quiet, pending_readings.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_MAX_ECHO;
    cfg_wdata    = '0;

    // Mirror the reset state of the ranger.
    cfg_max_echo  = MAX_ECHO_RST;
    cfg_margin    = MARGIN_RST;
    cfg_scale     = SCALE_RST;
    rg_phase      = PH_IDLE;
    rg_clock      = '0;
    rg_trigger_at = '0;
    rg_rise_at    = '0;
    rg_echo_last  = 1'b0;
    rg_pulse_step = '0;
    held_mm       = '0;
    held_valid    = 1'b0;
    held_inf      = 1'b0;
    held_stamp    = '0;

    // Hold reset, then release it at a falling edge.
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_defaults_and_idle_edges();
    test_pulse_restart_and_busy_start();
    test_echo_high_at_trigger();
    test_limits_and_timeouts();
    test_full_scale_registers();
    test_backpressure();
    test_random_measurements(RANDOM_TICKS);

    // Let every reading come out, then keep watching for stray beats.
    drain_readings();
    repeat (10) @(negedge clk);

    $display("covered %0d ticks: %0d finite readings (%0d clipped), %0d beyond limit, %0d timeouts",
             ticks_sent, n_finite, n_saturated, n_beyond, n_timeout);
    $display("%0d starts dropped while busy; %0d result beats compared, %0d bad",
             n_ignored_start, beats_seen, bad_beats);
    if (bad_beats == 0 && pending_readings.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
